// ----- design/wsm_pkg.sv -----
`default_nettype none

package wsm_pkg;

  localparam int MAX_ENTRIES  = 16;
  localparam int RESULT_LIMIT = 16;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int RES_W = $clog2(RESULT_LIMIT + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TIME  = 1'b1;

  localparam logic [1:0] REG_TASK_COUNT = 2'd0;
  localparam logic [1:0] REG_CHANNEL_A  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_B  = 2'd2;

  localparam logic [4:0] TASK_COUNT_RST = 5'd0;
  localparam logic [3:0] CHANNEL_A_RST  = 4'd13;
  localparam logic [3:0] CHANNEL_B_RST  = 4'd14;

  typedef struct packed {
    logic       active;
    logic       switch_on;
    logic [3:0] channel;
    logic [7:0] day_mask;
    logic [5:0] minute;
    logic [4:0] hour;
  } entry_t;

  typedef struct packed {
    logic [3:0] channel;
    logic       switch_on;
    logic [3:0] slot;
  } result_t;

endpackage

`default_nettype wire

// ----- design/wsm_table.sv -----
`default_nettype none

module wsm_table
  import wsm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t entry_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // entries never written read as cleared
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_addr] <= wr_data;
    end
    rd_data <= valid_r[rd_addr] ? entry_r[rd_addr] : '0;
  end

endmodule

`default_nettype wire

// ----- design/weekly_schedule_matcher.sv -----
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  cmd, slot, hour, minute, weekday, mask, channel, on, active
// out      output     out_valid/out_stall channel, on, slot, last
// cfg      input      cfg_valid/cfg_ready index (2 bits), data (5 bits)
//
// a write item, like a time item that is ignored, is done while the block stays idle; a time item that
// is handled takes a setup step, a scan step for each table entry in use and a closing flush step, and
// the next item is taken once the block is back in idle
// the scan steps the single entry comparator through the table
// reset is synchronous, active low, and clears the table and the handled minute
// a stalled output holds the scan when a result is pending and another match is waiting behind it
`default_nettype none

module weekly_schedule_matcher
  import wsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_cmd,
  input  wire logic [3:0] in_slot,
  input  wire logic [4:0] in_hour,
  input  wire logic [5:0] in_minute,
  input  wire logic [2:0] in_weekday,
  input  wire logic [7:0] in_day_mask,
  input  wire logic [3:0] in_target_channel,
  input  wire logic       in_switch_on,
  input  wire logic       in_active,

  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_channel,
  output logic            out_on,
  output logic [3:0]      out_slot,
  output logic            out_last,

  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [4:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_t;

  state_t           state_r, state_nxt;
  logic [4:0]       task_count_r, task_count_nxt;
  logic [3:0]       chan_a_r, chan_a_nxt;
  logic [3:0]       chan_b_r, chan_b_nxt;
  logic [5:0]       handled_minute_r, handled_minute_nxt;
  logic             handled_valid_r, handled_valid_nxt;
  logic [4:0]       hour_r, hour_nxt;
  logic [2:0]       weekday_r, weekday_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [RES_W-1:0] n_r, n_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  result_t          pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r, out_nxt;
  logic             out_last_r, out_last_nxt;

  logic             in_xfer;
  logic             wr_en;
  entry_t           wr_entry;
  entry_t           cur;
  logic             match;
  logic             out_free;
  logic             end_of_scan;
  result_t          cur_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;

  assign wr_en    = in_xfer && (in_cmd == CMD_WRITE) && (int'(in_slot) < MAX_ENTRIES);
  assign wr_entry = '{active: in_active, switch_on: in_switch_on,
                      channel: in_target_channel, day_mask: in_day_mask,
                      minute: in_minute, hour: in_hour};

  // entry for the next scan index is fetched from idx_nxt, so the registered read data lines up with idx_r
  wsm_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_slot)),
    .wr_data (wr_entry),
    .rd_addr (idx_nxt[IDX_W-1:0]),
    .rd_data (cur)
  );

  // single entry comparator shared across the scan
  assign match = cur.active && (cur.hour == hour_r) && (cur.minute == handled_minute_r)
                 && cur.day_mask[weekday_r]
                 && ((cur.channel == chan_a_r) || (cur.channel == chan_b_r))
                 && (int'(n_r) < RESULT_LIMIT);

  assign cur_res     = '{channel: cur.channel, switch_on: cur.switch_on, slot: 4'(idx_r)};
  assign out_free    = !out_valid_r || !out_stall;
  assign end_of_scan = ((idx_r + 1'b1) == limit_r);

  always_comb begin
    state_nxt          = state_r;
    task_count_nxt     = task_count_r;
    chan_a_nxt         = chan_a_r;
    chan_b_nxt         = chan_b_r;
    handled_minute_nxt = handled_minute_r;
    handled_valid_nxt  = handled_valid_r;
    hour_nxt           = hour_r;
    weekday_nxt        = weekday_r;
    idx_nxt            = idx_r;
    limit_nxt          = limit_r;
    n_nxt              = n_r;
    pend_valid_nxt     = pend_valid_r;
    pend_nxt           = pend_r;
    out_valid_nxt      = out_valid_r;
    out_nxt            = out_r;
    out_last_nxt       = out_last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TASK_COUNT: task_count_nxt = cfg_data;
        REG_CHANNEL_A:  chan_a_nxt     = cfg_data[3:0];
        REG_CHANNEL_B:  chan_b_nxt     = cfg_data[3:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_cmd == CMD_TIME) && (task_count_r != '0)
            && !(handled_valid_r && (in_minute == handled_minute_r))) begin
          handled_minute_nxt = in_minute;
          handled_valid_nxt  = 1'b1;
          hour_nxt           = in_hour;
          weekday_nxt        = in_weekday;
          idx_nxt            = '0;
          n_nxt              = '0;
          if (int'(task_count_r) > MAX_ENTRIES) begin
            limit_nxt = CNT_W'(MAX_ENTRIES);
          end else begin
            limit_nxt = CNT_W'(task_count_r);
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!(match && pend_valid_r && !out_free)) begin
          if (match) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_nxt       = cur_res;
            n_nxt          = n_r + 1'b1;
          end
          if (end_of_scan) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    hour_r     <= hour_nxt;
    weekday_r  <= weekday_nxt;
    idx_r      <= idx_nxt;
    limit_r    <= limit_nxt;
    n_r        <= n_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      task_count_r     <= TASK_COUNT_RST;
      chan_a_r         <= CHANNEL_A_RST;
      chan_b_r         <= CHANNEL_B_RST;
      handled_minute_r <= '0;
      handled_valid_r  <= 1'b0;
      pend_valid_r     <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      task_count_r     <= task_count_nxt;
      chan_a_r         <= chan_a_nxt;
      chan_b_r         <= chan_b_nxt;
      handled_minute_r <= handled_minute_nxt;
      handled_valid_r  <= handled_valid_nxt;
      pend_valid_r     <= pend_valid_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_r.channel;
  assign out_on      = out_r.switch_on;
  assign out_slot    = out_r.slot;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("pending result left behind in idle");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r < limit_r)
    else $error("scan index beyond entry count");

  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> int'(n_r) <= RESULT_LIMIT)
    else $error("result count over limit");

  a_scan_needs_minute: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> handled_valid_r)
    else $error("scan without a handled minute");
`endif

endmodule

`default_nettype wire
